/* rtl/waypoint_rotate_translate_follower_macros.svh */
// Assertion macros for the waypoint follower.
// Used by the top level only; no other dependencies.
`ifndef WAYPOINT_ROTATE_TRANSLATE_FOLLOWER_MACROS_SVH
`define WAYPOINT_ROTATE_TRANSLATE_FOLLOWER_MACROS_SVH
`define WRTF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define WRTF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/wrtf_pkg.sv */
// Package for the waypoint follower: widths, CORDIC angle table, sequencer states.
// No dependencies.
package wrtf_pkg;
   localparam int MAX_POINTS   = 16;
   localparam int SLOT_W       = $clog2(MAX_POINTS);
   localparam int CORDIC_STEPS = 20;
   localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
   localparam int CW           = 36;
   localparam int ZW           = 21;
   localparam logic signed [ZW-1:0] HALF_PI = ZW'(102944);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_POSE = 1'b1;
   localparam logic [1:0] CSR_ANG = 2'd0;
   localparam logic [1:0] CSR_DST = 2'd1;
   localparam logic [1:0] CSR_CNT = 2'd2;

   function automatic logic [16:0] atan_step(input logic [4:0] i);
      logic [16:0] r;
      unique case (i)
         5'd0: r = 17'd51472;  5'd1: r = 17'd30385;  5'd2: r = 17'd16055;
         5'd3: r = 17'd8150;   5'd4: r = 17'd4091;   5'd5: r = 17'd2047;
         5'd6: r = 17'd1024;   5'd7: r = 17'd512;    5'd8: r = 17'd256;
         5'd9: r = 17'd128;    5'd10: r = 17'd64;    5'd11: r = 17'd32;
         5'd12: r = 17'd16;    5'd13: r = 17'd8;     5'd14: r = 17'd4;
         5'd15: r = 17'd2;     5'd16: r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_FETCH = 7'b0000010,
      ST_SETUP = 7'b0000100,
      ST_SQ    = 7'b0001000,
      ST_ITER  = 7'b0010000,
      ST_EVAL  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic start;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
   } meas_ctl_type;

   typedef struct packed {
      logic done;
      logic signed [ZW-1:0] bearing;
      logic [32:0] distance;
   } meas_res_type;
endpackage

/* rtl/wrtf_measure.sv */
// Iterative measurement unit: CORDIC vectoring atan2 and a
// digit-by-digit square root, one step per cycle. Uses wrtf_pkg.
module wrtf_measure import wrtf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  meas_ctl_type ctl,
   output meas_res_type res
);
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [65:0] sum_ff, sum_in;
   logic [34:0] rem_ff, rem_in;
   logic [32:0] root_ff, root_in;
   logic [1:0] phase_ff, phase_in;
   logic [32:0] ax, ay;
   logic [65:0] sq;
   logic [34:0] remsh, trial;
   logic [1:0] pair;
   logic signed [CW-1:0] xs, ys;

   always_comb begin
      ax = ctl.dx[32] ? 33'(-ctl.dx) : 33'(ctl.dx);
      ay = ctl.dy[32] ? 33'(-ctl.dy) : 33'(ctl.dy);
      sq = 66'(phase_ff == 2'd0 ? ax : ay) * 66'(phase_ff == 2'd0 ? ax : ay);
      xs = x_ff >>> cnt_ff[4:0];
      ys = y_ff >>> cnt_ff[4:0];
      pair = sum_ff[65:64];
      remsh = {rem_ff[32:0], pair};
      trial = {root_ff[32:0] & 33'h0_FFFF_FFFF, 2'b01};
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      sum_in = sum_ff; rem_in = rem_ff; root_in = root_ff; phase_in = phase_ff;
      if (ctl.start) begin
         busy_in = 1'b1; cnt_in = '0; phase_in = 2'd0;
         sum_in = '0; rem_in = '0; root_in = '0;
         if (ctl.dx[32] && !ctl.dy[32]) begin
            x_in = CW'(ctl.dy); y_in = -CW'(ctl.dx); z_in = HALF_PI;
         end else if (ctl.dx[32]) begin
            x_in = -CW'(ctl.dy); y_in = CW'(ctl.dx); z_in = -HALF_PI;
         end else begin
            x_in = CW'(ctl.dx); y_in = CW'(ctl.dy); z_in = '0;
         end
         if (ctl.dx == '0 && ctl.dy == '0) y_in = '0;
      end else if (busy_ff) begin
         if (phase_ff != 2'd2) begin
            sum_in = sum_ff + sq;
            phase_in = phase_ff + 2'd1;
         end else begin
            if (cnt_ff < 6'(CORDIC_STEPS)) begin
               if (y_ff > 0) begin
                  x_in = x_ff + ys; y_in = y_ff - xs;
                  z_in = z_ff + ZW'(atan_step(cnt_ff[4:0]));
               end else if (y_ff < 0) begin
                  x_in = x_ff - ys; y_in = y_ff + xs;
                  z_in = z_ff - ZW'(atan_step(cnt_ff[4:0]));
               end
            end
            sum_in = {sum_ff[63:0], 2'b00};
            if (remsh >= trial) begin
               rem_in = remsh - trial; root_in = {root_ff[31:0], 1'b1};
            end else begin
               rem_in = remsh; root_in = {root_ff[31:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) begin
               busy_in = 1'b0; done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; cnt_ff <= cnt_in;
      sum_ff <= sum_in; rem_ff <= rem_in; root_ff <= root_in; phase_ff <= phase_in;
   end

   assign res.done = done_ff;
   assign res.bearing = z_ff;
   assign res.distance = root_ff;
endmodule

/* rtl/waypoint_rotate_translate_follower.sv */
// Waypoint follower top level: waypoint table, target index and sequencer.
// Uses wrtf_pkg, wrtf_measure and the assertion macro header.
//
// Usage: pulse start with busy low to issue a transaction. req_cmd 0 loads
// req_pos_x/req_pos_y into table slot req_point_slot on acceptance and gives
// no result. req_cmd 1 is a pose update: the block computes bearing (CORDIC
// vectoring) and distance (bit-serial square root) to the current waypoint,
// advances the target when both are within tolerance and measures again.
// Each measurement pass is fetch, setup, squaring of dx and dy, 33
// root/CORDIC steps and evaluation. The result shows for one cycle with
// rsp_valid; the receiver cannot stall. csr_* writes registers 0 angle,
// 1 distance tolerance, 2 point count; the user must write them only while
// idle, as the block itself does not enforce it. Reset clears the table,
// target index and registers to defaults.
`include "waypoint_rotate_translate_follower_macros.svh"
module waypoint_rotate_translate_follower import wrtf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_cmd,
   input  logic [3:0]          req_point_slot,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [18:0]  req_robot_heading,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data,
   output logic                rsp_valid,
   output logic                rsp_motion_mode,
   output logic signed [19:0]  rsp_turn_amount,
   output logic [32:0]         rsp_forward_amount,
   output logic [3:0]          rsp_target_slot
);
   state_type state_ff, state_in;
   logic signed [31:0] wx_ff [MAX_POINTS];
   logic signed [31:0] wy_ff [MAX_POINTS];
   logic [15:0] atol_ff, dtol_ff;
   logic [4:0] pcnt_ff;
   logic [SLOT_W-1:0] tgt_ff, tgt_in;
   logic signed [31:0] px_ff, py_ff;
   logic signed [18:0] hd_ff;
   logic second_ff, second_in;
   logic signed [32:0] dx_ff, dy_ff;
   logic rv_ff, mode_ff;
   logic signed [19:0] turn_ff;
   logic [32:0] fwd_ff;
   logic [4:0] count;
   logic signed [ZW-1:0] err;
   logic [ZW-1:0] aerr;
   logic ang_ok, dst_ok;
   meas_ctl_type mctl;
   meas_res_type mres;
   logic accept;

   assign accept = start && !busy;
   assign busy = state_ff != ST_IDLE;
   assign count = (pcnt_ff == 5'd0) ? 5'd1 :
                  (pcnt_ff > 5'(MAX_POINTS)) ? 5'(MAX_POINTS) : pcnt_ff;
   assign err = mres.bearing - ZW'(hd_ff);
   assign aerr = err[ZW-1] ? ZW'(-err) : ZW'(err);
   assign ang_ok = aerr <= ZW'(atol_ff);
   assign dst_ok = mres.distance <= 33'(dtol_ff);
   assign mctl.start = state_ff == ST_SETUP;
   assign mctl.dx = dx_ff;
   assign mctl.dy = dy_ff;

   wrtf_measure u_meas (.clock(clock), .reset(reset), .ctl(mctl), .res(mres));

   always_comb begin
      state_in = state_ff; tgt_in = tgt_ff; second_in = second_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && req_cmd == CMD_POSE) begin
            state_in = ST_FETCH; second_in = 1'b0;
            if (5'(tgt_ff) >= count) tgt_in = '0;
         end
         ST_FETCH: state_in = ST_SETUP;
         ST_SETUP: state_in = ST_SQ;
         ST_SQ:    state_in = ST_ITER;
         ST_ITER:  if (mres.done) state_in = ST_EVAL;
         ST_EVAL: begin
            if (!second_ff && ang_ok && dst_ok) begin
               second_in = 1'b1; state_in = ST_FETCH;
               tgt_in = (5'(tgt_ff) + 5'd1 >= count) ? '0 : tgt_ff + 1'b1;
            end else state_in = ST_OUT;
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; tgt_ff <= '0; second_ff <= 1'b0;
         atol_ff <= 16'd1; dtol_ff <= 16'd1; pcnt_ff <= 5'd1; rv_ff <= 1'b0;
         for (int i = 0; i < MAX_POINTS; i++) begin
            wx_ff[i] <= '0; wy_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in; tgt_ff <= tgt_in; second_ff <= second_in;
         rv_ff <= state_ff == ST_EVAL && state_in == ST_OUT;
         if (csr_write) begin
            if (csr_index == CSR_ANG) atol_ff <= csr_data;
            else if (csr_index == CSR_DST) dtol_ff <= csr_data;
            else if (csr_index == CSR_CNT) pcnt_ff <= csr_data[4:0];
         end
         if (accept && req_cmd == CMD_LOAD) begin
            wx_ff[req_point_slot] <= req_pos_x;
            wy_ff[req_point_slot] <= req_pos_y;
         end
      end
      if (accept) begin
         px_ff <= req_pos_x; py_ff <= req_pos_y; hd_ff <= req_robot_heading;
      end
      if (state_ff == ST_FETCH) begin
         dx_ff <= 33'(wx_ff[tgt_ff]) - 33'(px_ff);
         dy_ff <= 33'(wy_ff[tgt_ff]) - 33'(py_ff);
      end
      if (state_ff == ST_EVAL) begin
         mode_ff <= ang_ok;
         turn_ff <= ang_ok ? '0 : 20'(err);
         fwd_ff <= ang_ok ? mres.distance : '0;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_motion_mode = mode_ff;
   assign rsp_turn_amount = turn_ff;
   assign rsp_forward_amount = fwd_ff;
   assign rsp_target_slot = tgt_ff;

   `WRTF_ASSERT_IMPL(a_rsp_busy, clock, reset, rsp_valid, state_ff == ST_OUT, "result off turn")
   `WRTF_ASSERT_NEXT(a_pose_busy, clock, reset, accept && req_cmd == CMD_POSE, busy, "pose not busy")
   `WRTF_ASSERT_IMPL(a_tgt_range, clock, reset, rsp_valid, 5'(rsp_target_slot) < count, "target out of range")
endmodule
